### src/b2a_pkg.sv
package b2a_pkg;

    localparam logic [5:0] C_SIX_THRESH = 6'h26;
    localparam logic [6:0] C_UPPER_OFS  = 7'h3b;
    localparam logic [4:0] C_FIVE_SPLIT = 5'h06;
    localparam logic [6:0] C_DIGIT_OFS  = 7'h30;
    localparam logic [6:0] C_TERMINATOR = 7'h39;

    localparam logic C_KIND_DATA = 1'b0;
    localparam logic C_KIND_END  = 1'b1;

    // Result of one input item, plus the residue it leaves behind.
    typedef struct packed {
        logic [6:0] char0;
        logic [6:0] char1;
        logic       two;
        logic [4:0] res_bits;
        logic [2:0] res_cnt;
    } t_step_res;

    function automatic logic [6:0] map_five(input logic [4:0] v);
        logic [6:0] ch;
        if (v >= C_FIVE_SPLIT) begin
            ch = {2'b00, v} + C_UPPER_OFS;
        end else begin
            ch = {2'b00, v} + C_DIGIT_OFS;
        end
        return ch;
    endfunction

endpackage

### src/b2a_step.sv
module b2a_step (
    input  logic                 i_kind,
    input  logic [7:0]           i_byte,
    input  logic [4:0]           i_res_bits,
    input  logic [2:0]           i_res_cnt,
    output b2a_pkg::t_step_res   o_res
);

    typedef struct packed {
        logic [6:0]  ch;
        logic [3:0]  cnt;
        logic [12:0] val;
    } t_take;

    // Takes one character from the top of a buffer holding c valid bits (c >= 6).
    function automatic t_take take_one(input logic [12:0] v, input logic [3:0] c);
        t_take       t;
        logic [12:0] sh;
        logic [5:0]  top6;
        sh   = v >> (c - 4'd6);
        top6 = sh[5:0];
        if (top6 >= b2a_pkg::C_SIX_THRESH) begin
            t.ch  = {1'b0, top6} + b2a_pkg::C_UPPER_OFS;
            t.cnt = c - 4'd6;
        end else begin
            t.ch  = b2a_pkg::map_five(sh[5:1]);
            t.cnt = c - 4'd5;
        end
        t.val = v & ((13'd1 << t.cnt) - 13'd1);
        return t;
    endfunction

    logic [4:0]  res_mask;
    logic [4:0]  res_val;
    logic [4:0]  flush_v;
    logic [12:0] buf_val;
    logic [3:0]  buf_cnt;
    t_take       take_a;
    t_take       take_b;

    always_comb begin
        res_mask = 5'((6'd1 << i_res_cnt) - 6'd1);
        res_val  = i_res_bits & res_mask;
        flush_v  = res_val << (3'd5 - i_res_cnt);
        buf_val  = {res_val, i_byte};
        buf_cnt  = {1'b0, i_res_cnt} + 4'd8;
        take_a   = take_one(buf_val, buf_cnt);
        take_b   = take_one(take_a.val, take_a.cnt);

        o_res = '0;
        if (i_kind == b2a_pkg::C_KIND_END) begin
            if (i_res_cnt != 3'd0) begin
                o_res.char0 = b2a_pkg::map_five(flush_v);
                o_res.char1 = b2a_pkg::C_TERMINATOR;
                o_res.two   = 1'b1;
            end else begin
                o_res.char0 = b2a_pkg::C_TERMINATOR;
                o_res.char1 = b2a_pkg::C_TERMINATOR;
                o_res.two   = 1'b0;
            end
        end else begin
            o_res.char0 = take_a.ch;
            o_res.char1 = take_b.ch;
            if (take_a.cnt >= 4'd6) begin
                o_res.two      = 1'b1;
                o_res.res_bits = take_b.val[4:0];
                o_res.res_cnt  = take_b.cnt[2:0];
            end else begin
                o_res.two      = 1'b0;
                o_res.res_bits = take_a.val[4:0];
                o_res.res_cnt  = take_a.cnt[2:0];
            end
        end
    end

endmodule

### src/bits_to_alphanumeric_encoder.sv
// Re-codes a byte stream into alphanumeric characters. Each data item (tuser = 0)
// yields one or two characters, an end-of-message item (tuser = 1) yields the
// flushed leftover bits as one character if any are held, then the terminator
// '9', and starts a new message. tlast marks the final character of each input
// item. An item is registered on entry and coded into a two-character output
// register once that register is free; the output port sets the limit at one
// character per cycle, less while m_axis_tready is low.
module bits_to_alphanumeric_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast    // last_of_run
);

    logic               r_in_valid;
    logic               r_in_kind;
    logic [7:0]         r_in_byte;
    logic [4:0]         r_res_bits;
    logic [2:0]         r_res_cnt;
    logic               r_pv;
    logic               r_sel;
    logic               r_two;
    logic [6:0]         r_c0;
    logic [6:0]         r_c1;
    b2a_pkg::t_step_res step_res;
    logic               take_last;
    logic               pair_load;

    b2a_step u_step (
        .i_kind     (r_in_kind),
        .i_byte     (r_in_byte),
        .i_res_bits (r_res_bits),
        .i_res_cnt  (r_res_cnt),
        .o_res      (step_res)
    );

    assign m_axis_tvalid = r_pv;
    assign m_axis_tdata  = {1'b0, (r_sel ? r_c1 : r_c0)};
    assign m_axis_tlast  = r_sel | ~r_two;
    assign take_last     = r_pv & m_axis_tready & m_axis_tlast;
    assign pair_load     = r_in_valid & (~r_pv | take_last);
    assign s_axis_tready = ~r_in_valid | pair_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_res_bits <= '0;
            r_res_cnt  <= '0;
            r_pv       <= 1'b0;
            r_sel      <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (pair_load) begin
                r_res_bits <= step_res.res_bits;
                r_res_cnt  <= step_res.res_cnt;
                r_pv       <= 1'b1;
                r_sel      <= 1'b0;
            end else if (take_last) begin
                r_pv  <= 1'b0;
                r_sel <= 1'b0;
            end else if (r_pv && m_axis_tready) begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
        if (pair_load) begin
            r_c0  <= step_res.char0;
            r_c1  <= step_res.char1;
            r_two <= step_res.two;
        end
    end

`ifndef SYNTH
    a_sel_only_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (r_pv && r_two))
        else $error("second character selected without a pair");

    a_res_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= 3'd5)
        else $error("residue count above five");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pair_load && r_in_kind == b2a_pkg::C_KIND_END) |=> (r_res_cnt == 3'd0))
        else $error("end of message did not clear the residue");

    a_pair_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && r_sel))
        else $error("second character of a pair was lost");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import b2a_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 1300;
    localparam int TAIL_CYCLES    = 16;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_code_rec;

    // Tracks the bit residue of the message in flight and holds the characters
    // that are still owed by the encoder.
    class char_ledger;
        logic [4:0]  held_bits;
        logic [2:0]  held_cnt;
        t_code_rec   owed[$];
        int unsigned faults;

        function new();
            held_bits = '0;
            held_cnt  = '0;
            faults    = 0;
        endfunction

        function logic [6:0] letter_of(logic [4:0] v);
            logic [6:0] ch;
            if (v >= C_FIVE_SPLIT) begin
                ch = {2'b00, v} + C_UPPER_OFS;
            end else begin
                ch = {2'b00, v} + C_DIGIT_OFS;
            end
            return ch;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_item(logic kind, logic [7:0] data);
            logic [12:0] acc;
            logic [5:0]  top6;
            logic [4:0]  top5;
            logic [4:0]  pad;
            logic [6:0]  chars[2];
            int          n;
            int          nchars;
            nchars = 0;
            if (kind == C_KIND_END) begin
                if (held_cnt != 0) begin
                    // Leftover bits are left-aligned into a 5-bit group.
                    pad = held_bits << (3'd5 - held_cnt);
                    chars[nchars] = letter_of(pad);
                    nchars++;
                end
                chars[nchars] = C_TERMINATOR;
                nchars++;
                held_bits = '0;
                held_cnt  = '0;
            end else begin
                acc = {held_bits, data};
                n   = held_cnt + 8;
                while (n >= 6) begin
                    top6 = 6'(acc >> (n - 6));
                    if (top6 >= C_SIX_THRESH) begin
                        chars[nchars] = {1'b0, top6} + C_UPPER_OFS;
                        n = n - 6;
                    end else begin
                        top5 = 5'(acc >> (n - 5));
                        chars[nchars] = letter_of(top5);
                        n = n - 5;
                    end
                    nchars++;
                    acc = acc & ((13'd1 << n) - 13'd1);
                end
                held_bits = acc[4:0];
                held_cnt  = 3'(n);
            end
            for (int i = 0; i < nchars; i++) begin
                owed.push_back('{code: chars[i], last: (i == nchars - 1)});
            end
        endfunction

        function void check_char(logic [7:0] tdata, logic tlast);
            t_code_rec want;
            if (owed.size() == 0) begin
                $error("out_char: expected nothing, got %h", tdata[6:0]);
                faults++;
                return;
            end
            want = owed.pop_front();
            if (tdata[6:0] !== want.code) begin
                $error("out_char: expected %h, got %h", want.code, tdata[6:0]);
                faults++;
            end
            if (tlast !== want.last) begin
                $error("last_of_run: expected %b, got %b", want.last, tlast);
                faults++;
            end
            if (tdata[7] !== 1'b0) begin
                $error("tdata pad bit: expected 0, got %b", tdata[7]);
                faults++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       s_axis_tuser = 1'b0;    // [0] kind
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [6:0] out_char, [7] zero
    logic       m_axis_tlast;           // last_of_run

    char_ledger ledger;
    bit         calm = 1'b0;
    int         items_sent = 0;
    int         quiet_cycles = 0;

    bits_to_alphanumeric_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic push_item(input logic kind, input logic [7:0] data);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_item(kind, data);
        items_sent++;
    endtask

    task automatic push_message(input int len);
        for (int i = 0; i < len; i++) begin
            push_item(C_KIND_DATA, 8'($urandom_range(0, 255)));
        end
        push_item(C_KIND_END, 8'($urandom_range(0, 255)));
    endtask

    // Output side: random stalls between characters, none while calm.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            ledger.check_char(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic       kinds[24];
        logic [7:0] bytes[24];
        int         len;
        ledger = new();
        kinds = '{C_KIND_END,  C_KIND_DATA, C_KIND_END,  C_KIND_DATA, C_KIND_END,
                  C_KIND_DATA, C_KIND_END,  C_KIND_DATA, C_KIND_END,  C_KIND_DATA,
                  C_KIND_DATA, C_KIND_END,  C_KIND_DATA, C_KIND_DATA, C_KIND_END,
                  C_KIND_DATA, C_KIND_DATA, C_KIND_DATA, C_KIND_DATA, C_KIND_END,
                  C_KIND_DATA, C_KIND_DATA, C_KIND_DATA, C_KIND_END};
        bytes = '{8'hA5, 8'h00, 8'hFF, 8'hFF, 8'h00,
                  8'h98, 8'h5A, 8'h94, 8'h00, 8'hFF,
                  8'hFF, 8'h3C, 8'h00, 8'h00, 8'hC3,
                  8'h80, 8'h7F, 8'h55, 8'hAA, 8'h01,
                  8'h04, 8'h2C, 8'hFE, 8'hFF};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes, both sides of the 6-bit threshold, flushes of various
        // residue sizes, and an end of message with nothing held.
        for (int i = 0; i < 24; i++) begin
            push_item(kinds[i], bytes[i]);
        end

        while (items_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // Loose items with a random kind, not shaped into messages.
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
            end else if ($urandom_range(0, 7) == 0) begin
                push_message($urandom_range(13, 40));
            end else begin
                push_message($urandom_range(0, 12));
            end
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (ledger.faults == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### bits_to_alphanumeric_encoder.f
src/b2a_pkg.sv
src/b2a_step.sv
src/bits_to_alphanumeric_encoder.sv
sim/testbench.sv
